// ----- design/shq_pkg.sv -----
// ----------------------------------------------------------------------------
// shq_pkg: shared types and constants of the sorted histogram quantile core
// Entry layout, action codes, datapath result bundle and the percent table.
// ----------------------------------------------------------------------------
package shq_pkg;

  localparam int VAL_W   = 32;
  localparam int CNT_W   = 32;
  localparam int ENTRY_W = VAL_W + CNT_W;
  localparam int TOT_W   = 24;
  localparam int PCT_W   = 7;
  localparam int THR_W   = PCT_W + TOT_W;
  // cumulative count saturates here; any value at the ceiling already
  // clears the largest threshold (95 * 2^24 < 100 * 2^26)
  localparam int CUM_W   = 26;

  localparam logic [TOT_W-1:0] TOTAL_RESET = 24'd1000;
  localparam logic [2:0]       PICK_LAST   = 3'd4;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_QUANT = 2'd1,
    ACT_MIN   = 2'd2,
    ACT_MAX   = 2'd3
  } action_t;

  typedef enum logic {
    ALU_ACC = 1'b0,
    ALU_INC = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
  } entry_t;

  typedef struct packed {
    logic             eq;
    logic             lt;
    logic [CNT_W-1:0] cnt_inc;
    logic [CUM_W-1:0] cum_sum;
    logic             hit;
  } alu_res_t;

  function automatic logic [PCT_W-1:0] pct_of(logic [2:0] pick);
    logic [PCT_W-1:0] pct;
    unique case (pick)
      3'd0:    pct = 7'd5;
      3'd1:    pct = 7'd25;
      3'd2:    pct = 7'd50;
      3'd3:    pct = 7'd75;
      3'd4:    pct = 7'd95;
      default: pct = 7'd0;
    endcase
    return pct;
  endfunction

endpackage

// ----- design/shq_ram.sv -----
// ----------------------------------------------------------------------------
// shq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module shq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/shq_alu.sv -----
// ----------------------------------------------------------------------------
// shq_alu: shared compare and add unit
// Signed compare of the sample against a stored value, one saturating adder
// (count increment or cumulative sum) and the threshold test cum*100 >= thr.
// ----------------------------------------------------------------------------
module shq_alu (
  input  shq_pkg::alu_op_t                op,
  input  logic signed [shq_pkg::VAL_W-1:0] sample,
  input  shq_pkg::entry_t                 ent,
  input  logic [shq_pkg::CUM_W-1:0]       cum_in,
  input  logic [shq_pkg::THR_W-1:0]       thr,
  output shq_pkg::alu_res_t               res
);
  import shq_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  logic [SUM_W-1:0] opa;
  logic [SUM_W-1:0] opb;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] cum_ext;
  logic [SUM_W-1:0] prod100;

  assign cum_ext = {{(SUM_W-CUM_W){1'b0}}, cum_in};

  always_comb begin
    unique case (op)
      ALU_INC: begin
        opa = {1'b0, ent.count};
        opb = SUM_W'(1);
      end
      ALU_ACC: begin
        opa = cum_ext;
        opb = {1'b0, ent.count};
      end
    endcase
    sum = opa + opb;
  end

  // cum*100 as shift-add: 64 + 32 + 4
  assign prod100 = (cum_ext << 6) + (cum_ext << 5) + (cum_ext << 2);

  always_comb begin
    res.eq      = (sample == $signed(ent.value));
    res.lt      = (sample < $signed(ent.value));
    res.cnt_inc = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    res.cum_sum = (|sum[SUM_W-1:CUM_W]) ? {CUM_W{1'b1}} : sum[CUM_W-1:0];
    res.hit     = (prod100 >= {{(SUM_W-THR_W){1'b0}}, thr});
  end

endmodule

// ----- design/sorted_histogram_quantile_core.sv -----
// ----------------------------------------------------------------------------
// sorted_histogram_quantile_core: sorted value histogram with quantile lookup
// Keeps distinct values in ascending order with occurrence counts in one
// RAM; answers push, quantile, min and max requests one at a time.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                         | tuser
//  ---------+-----------+-------------------------------+----------------------
//  in_      | slave     | [31:0] sample_value,          | [1:0] action
//           |           | [34:32] quantile_pick         |
//  out_     | master    | [31:0] result_value           | [0] not_found,
//           |           |                               | [1] table_full
//  cfg_     | write     | cfg_wr_data: total_samples    | -
//
//  Push and quantile transactions walk the entries in use, and every walk
//  shares the single RAM read port. After reset the core writes the
//  sentinel entry in its init state before in_tready rises. A result
//  waiting on out_tready holds the core in its finish step only once the
//  next transaction is done; in_tready stays high in idle meanwhile.
// ----------------------------------------------------------------------------
module sorted_histogram_quantile_core #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] sample_value, [34:32] quantile_pick, [39:35] zero
  input  logic [39:0] in_tdata,
  // in_tuser: [1:0] action
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [31:0] result_value
  output logic [31:0] out_tdata,
  // out_tuser: [0] not_found, [1] table_full
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  import shq_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int USE_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [USE_W-1:0] USE_MAX = USE_W'(MAX_ENTRIES);
  localparam logic [USE_W-1:0] USE_ONE = USE_W'(1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PSCAN, S_PSHIFT, S_PINS, S_QTHR, S_QWALK,
    S_MIN0, S_MIN1, S_MAX, S_FIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic signed [VAL_W-1:0] sample_r, sample_nxt;
  logic [2:0]              pick_r, pick_nxt;
  logic [USE_W-1:0]        used_r, used_nxt;
  logic [USE_W-1:0]        a_r, a_nxt;
  logic [USE_W-1:0]        c_r, c_nxt;
  logic [USE_W-1:0]        ci_r, ci_nxt;
  logic [USE_W-1:0]        pos_r, pos_nxt;
  logic                    pend_r, pend_nxt;
  logic                    idone_r, idone_nxt;
  logic                    cv_r, cv_nxt;
  logic [CUM_W-1:0]        cum_r, cum_nxt;
  logic signed [VAL_W-1:0] vd_r, vd_nxt;
  logic [THR_W-1:0]        thr_r, thr_nxt;
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  logic                    res_nf_r, res_nf_nxt;
  logic                    res_full_r, res_full_nxt;
  logic [31:0]             out_data_r, out_data_nxt;
  logic [1:0]              out_user_r, out_user_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_ent;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t           rd_ent;
  alu_op_t          alu_op;
  alu_res_t         alu_res;
  logic [USE_W-1:0] ins_pos;
  logic             ins_go;
  logic [USE_W-1:0] wr_next;

  assign rd_ent = entry_t'(rd_raw);

  shq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_ent)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  shq_alu u_alu (
    .op     (alu_op),
    .sample (sample_r),
    .ent    (rd_ent),
    .cum_in (cum_r),
    .thr    (thr_r),
    .res    (alu_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;
  assign wr_next    = c_r + USE_ONE;

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    pick_nxt      = pick_r;
    used_nxt      = used_r;
    a_nxt         = a_r;
    c_nxt         = c_r;
    ci_nxt        = ci_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    idone_nxt     = idone_r;
    cv_nxt        = cv_r;
    cum_nxt       = cum_r;
    vd_nxt        = vd_r;
    thr_nxt       = thr_r;
    res_val_nxt   = res_val_r;
    res_nf_nxt    = res_nf_r;
    res_full_nxt  = res_full_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r;
    total_nxt     = cfg_wr_en ? cfg_wr_data : total_r;

    rd_en   = 1'b0;
    rd_addr = a_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_ent  = '0;
    alu_op  = ALU_ACC;
    ins_pos = used_r;
    ins_go  = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        // sentinel: value 0, count 0
        wr_en     = 1'b1;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_tvalid) begin
          sample_nxt   = $signed(in_tdata[31:0]);
          pick_nxt     = in_tdata[34:32];
          a_nxt        = '0;
          pend_nxt     = 1'b0;
          cv_nxt       = 1'b0;
          cum_nxt      = '0;
          res_val_nxt  = '0;
          res_nf_nxt   = 1'b0;
          res_full_nxt = 1'b0;
          unique case (action_t'(in_tuser))
            ACT_PUSH:  state_nxt = S_PSCAN;
            ACT_QUANT: begin
              if (in_tdata[34:32] > PICK_LAST) begin
                res_nf_nxt = 1'b1;
                state_nxt  = S_FIN;
              end else begin
                state_nxt  = S_QTHR;
              end
            end
            ACT_MIN: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_MIN0;
            end
            ACT_MAX: begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(used_r - USE_ONE);
              state_nxt = S_MAX;
            end
          endcase
        end
      end

      S_PSCAN: begin
        if (a_r < used_r) begin
          rd_en    = 1'b1;
          a_nxt    = a_r + USE_ONE;
          c_nxt    = a_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          alu_op = ALU_INC;
          if (alu_res.eq) begin
            wr_en        = 1'b1;
            wr_addr      = c_r[IDX_W-1:0];
            wr_ent.value = rd_ent.value;
            wr_ent.count = alu_res.cnt_inc;
            state_nxt    = S_FIN;
          end else if (alu_res.lt) begin
            ins_pos = c_r;
            ins_go  = 1'b1;
          end else if (c_r == used_r - USE_ONE) begin
            ins_pos = used_r;
            ins_go  = 1'b1;
          end
        end
        if (ins_go) begin
          pos_nxt = ins_pos;
          if (used_r >= USE_MAX) begin
            res_full_nxt = 1'b1;
            state_nxt    = S_FIN;
          end else if (ins_pos < used_r) begin
            a_nxt     = used_r - USE_ONE;
            pend_nxt  = 1'b0;
            idone_nxt = 1'b0;
            state_nxt = S_PSHIFT;
          end else begin
            state_nxt = S_PINS;
          end
        end
      end

      S_PSHIFT: begin
        // read from the top down, write each entry one slot higher
        if (!idone_r) begin
          rd_en    = 1'b1;
          c_nxt    = a_r;
          pend_nxt = 1'b1;
          if (a_r == pos_r) begin
            idone_nxt = 1'b1;
          end else begin
            a_nxt = a_r - USE_ONE;
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_next[IDX_W-1:0];
          wr_ent  = rd_ent;
          if (idone_r) begin
            state_nxt = S_PINS;
          end
        end
      end

      S_PINS: begin
        wr_en        = 1'b1;
        wr_addr      = pos_r[IDX_W-1:0];
        wr_ent.value = sample_r;
        wr_ent.count = CNT_W'(1);
        used_nxt     = used_r + USE_ONE;
        state_nxt    = S_FIN;
      end

      S_QTHR: begin
        thr_nxt   = {{(THR_W-PCT_W){1'b0}}, pct_of(pick_r)}
                  * {{(THR_W-TOT_W){1'b0}}, total_r};
        state_nxt = S_QWALK;
      end

      S_QWALK: begin
        // three steps in flight: read issue, accumulate, threshold test
        if (a_r < used_r) begin
          rd_en    = 1'b1;
          a_nxt    = a_r + USE_ONE;
          c_nxt    = a_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          cum_nxt = alu_res.cum_sum;
          vd_nxt  = rd_ent.value;
          ci_nxt  = c_r;
          cv_nxt  = 1'b1;
        end else begin
          cv_nxt  = 1'b0;
        end
        if (cv_r) begin
          if (alu_res.hit) begin
            res_val_nxt = vd_r;
            state_nxt   = S_FIN;
          end else if (ci_r == used_r - USE_ONE) begin
            res_nf_nxt  = 1'b1;
            state_nxt   = S_FIN;
          end
        end
      end

      S_MIN0: begin
        if (rd_ent.count != '0) begin
          res_val_nxt = rd_ent.value;
          state_nxt   = S_FIN;
        end else if (used_r > USE_ONE) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(1);
          state_nxt = S_MIN1;
        end else begin
          res_nf_nxt = 1'b1;
          state_nxt  = S_FIN;
        end
      end

      S_MIN1, S_MAX: begin
        res_val_nxt = rd_ent.value;
        state_nxt   = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = res_val_r;
          out_user_nxt  = {res_full_r, res_nf_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      used_r      <= USE_ONE;
      a_r         <= '0;
      c_r         <= '0;
      ci_r        <= '0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      idone_r     <= 1'b0;
      cv_r        <= 1'b0;
      cum_r       <= '0;
      total_r     <= TOTAL_RESET;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_user_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      a_r         <= a_nxt;
      c_r         <= c_nxt;
      ci_r        <= ci_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      idone_r     <= idone_nxt;
      cv_r        <= cv_nxt;
      cum_r       <= cum_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_user_r  <= out_user_nxt;
    end
    sample_r   <= sample_nxt;
    pick_r     <= pick_nxt;
    vd_r       <= vd_nxt;
    thr_r      <= thr_nxt;
    res_val_r  <= res_val_nxt;
    res_nf_r   <= res_nf_nxt;
    res_full_r <= res_full_nxt;
  end

  // fill count stays within the table
  a_used_range : assert property (@(posedge clk) disable iff (!rst_n)
    (used_r >= USE_ONE) && (used_r <= USE_MAX))
    else $error("entry count out of range");

  // a dropped push only happens with the table full
  a_full_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[1]) |-> (used_r == USE_MAX))
    else $error("table_full reported with room left");

  // no transaction is both a miss and a dropped push
  a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_user_r[0] && out_user_r[1]))
    else $error("not_found and table_full both set");

  // a miss carries a zero value
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[0]) |-> (out_data_r == '0))
    else $error("not_found with nonzero result_value");

endmodule

// ----- sim/sorted_histogram_quantile_core_test.sv -----
// ----------------------------------------------------------------------------
// sorted_histogram_quantile_core_test: self-checking bench for the core
// Drives push, quantile, min and max transactions with random idle cycles
// on both streams, predicts every answer from a local copy of the sorted
// table and the total register, and compares each result field by field.
// ----------------------------------------------------------------------------
module sorted_histogram_quantile_core_test;
  import shq_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int TABLE_DEPTH    = 256;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 32;
  localparam int RX_HOLD_CYCLES = 3000;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [2:0] PICK_P5        = 3'd0;
  localparam logic [2:0] PICK_P25       = 3'd1;
  localparam logic [2:0] PICK_P50       = 3'd2;
  localparam logic [2:0] PICK_P75       = 3'd3;
  localparam logic [2:0] PICK_P95       = 3'd4;
  localparam logic [2:0] PICK_UNUSED_LO = 3'd5;
  localparam logic [2:0] PICK_UNUSED_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MOST_POS = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    not_found;
    logic                    table_full;
  } hist_answer_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;

  // local copy of the table and the total register
  logic signed [VAL_W-1:0] hist_value [0:TABLE_DEPTH-1];
  logic [CNT_W-1:0]        hist_count [0:TABLE_DEPTH-1];
  int                      hist_used;
  logic [TOT_W-1:0]        total_cfg;

  hist_answer_t answers_due[$];
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  bit           idle_on        = 1'b1;
  bit           rx_hold_req    = 1'b0;
  int           rx_hold_left   = 0;

  sorted_histogram_quantile_core #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Apply one transaction to the local table and return its answer.
  function automatic hist_answer_t histogram_answer(action_t act,
                                                    logic signed [VAL_W-1:0] sample,
                                                    logic [2:0] pick);
    hist_answer_t ans;
    int           slot;
    int           k;
    bit           seen;
    logic [6:0]   pct;
    logic [63:0]  cum;
    logic [63:0]  thresh;
    ans = '0;
    case (act)
      ACT_PUSH: begin
        slot = 0;
        seen = 1'b0;
        while (slot < hist_used && !seen && sample >= hist_value[slot]) begin
          if (sample == hist_value[slot]) seen = 1'b1;
          else slot++;
        end
        if (seen) begin
          if (hist_count[slot] != '1) hist_count[slot]++;
        end else if (hist_used >= TABLE_DEPTH) begin
          ans.table_full = 1'b1;
        end else begin
          // open a gap at the insertion point
          for (k = hist_used; k > slot; k--) begin
            hist_value[k] = hist_value[k-1];
            hist_count[k] = hist_count[k-1];
          end
          hist_value[slot] = sample;
          hist_count[slot] = CNT_W'(1);
          hist_used++;
        end
      end
      ACT_QUANT: begin
        case (pick)
          PICK_P5:  pct = 7'd5;
          PICK_P25: pct = 7'd25;
          PICK_P50: pct = 7'd50;
          PICK_P75: pct = 7'd75;
          PICK_P95: pct = 7'd95;
          default:  pct = 7'd0;
        endcase
        ans.not_found = 1'b1;
        if (pick <= PICK_LAST) begin
          thresh = 64'(pct) * 64'(total_cfg);
          cum = '0;
          for (k = 0; k < hist_used && ans.not_found; k++) begin
            cum += 64'(hist_count[k]);
            if (cum * 64'd100 >= thresh) begin
              ans.not_found = 1'b0;
              ans.value = hist_value[k];
            end
          end
        end
      end
      ACT_MIN: begin
        // skip the sentinel while nothing has landed on it
        if (hist_count[0] != 0) ans.value = hist_value[0];
        else if (hist_used > 1) ans.value = hist_value[1];
        else ans.not_found = 1'b1;
      end
      default: begin
        ans.value = hist_value[hist_used-1];
      end
    endcase
    return ans;
  endfunction

  // Predict at input acceptance, check at output acceptance.
  always @(posedge clk) begin
    hist_answer_t exp_ans;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual value %0d tuser %b",
                   $time, $signed(out_tdata), out_tuser);
        end else begin
          exp_ans = answers_due.pop_front();
          if ($signed(out_tdata) !== exp_ans.value) begin
            mismatch_count++;
            $display("%0t: result_value expected %0d actual %0d",
                     $time, exp_ans.value, $signed(out_tdata));
          end
          if (out_tuser[0] !== exp_ans.not_found) begin
            mismatch_count++;
            $display("%0t: not_found expected %b actual %b",
                     $time, exp_ans.not_found, out_tuser[0]);
          end
          if (out_tuser[1] !== exp_ans.table_full) begin
            mismatch_count++;
            $display("%0t: table_full expected %b actual %b",
                     $time, exp_ans.table_full, out_tuser[1]);
          end
        end
      end
      if (in_tvalid && in_tready)
        answers_due.insert(answers_due.size(),
                           histogram_answer(action_t'(in_tuser),
                                            in_tdata[31:0], in_tdata[34:32]));
    end
  end

  // Receiver: random idle cycles, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      out_tready = 1'b0;
      rx_hold_left--;
    end else begin
      out_tready = !(idle_on && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAIL sorted_histogram_quantile_core");
      $finish;
    end
  end

  task automatic send_item(input action_t act, input logic signed [VAL_W-1:0] sample,
                           input logic [2:0] pick);
    if (idle_on && $urandom_range(99) < 10) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tdata  = {5'd0, pick, sample};
    in_tuser  = act;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_random_item(input bit favor_stored);
    int                      roll;
    action_t                 act;
    logic signed [VAL_W-1:0] sample;
    logic [2:0]              pick;
    roll = $urandom_range(99);
    act  = (roll < 45) ? ACT_PUSH : (roll < 80) ? ACT_QUANT : (roll < 90) ? ACT_MIN : ACT_MAX;
    pick = ($urandom_range(9) == 0) ? 3'($urandom_range(PICK_UNUSED_LO, PICK_UNUSED_HI))
                                    : 3'($urandom_range(PICK_P5, PICK_P95));
    roll = $urandom_range(99);
    if (favor_stored && roll < 60) begin
      sample = hist_value[$urandom_range(0, hist_used - 1)];
    end else if (roll < 70) begin
      // narrow pool in steps of 2500 so that values repeat often
      sample = (int'($urandom_range(0, 63)) - 32) * 2500;
    end else if (roll < 85) begin
      sample = $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0:       sample = VAL_MOST_NEG;
        1:       sample = VAL_MOST_POS;
        2:       sample = -1;
        3:       sample = 1;
        default: sample = 0;
      endcase
    end
    send_item(act, sample, pick);
  endtask

  task automatic wait_drained();
    while (answers_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_total(input logic [TOT_W-1:0] total);
    wait_drained();
    cfg_wr_data = total;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    total_cfg   = total;
  endtask

  task automatic test_empty_table();
    send_item(ACT_MIN, 0, PICK_P5);
    send_item(ACT_MAX, 0, PICK_P5);
    send_item(ACT_QUANT, 0, PICK_P50);
    send_item(ACT_QUANT, 0, PICK_UNUSED_HI);
    // zero lands on the sentinel entry
    send_item(ACT_PUSH, 0, PICK_P5);
    send_item(ACT_MIN, 0, PICK_P5);
    send_item(ACT_QUANT, 0, PICK_P5);
    write_total(24'd1);
    send_item(ACT_QUANT, 0, PICK_P5);
  endtask

  task automatic test_edge_values();
    send_item(ACT_PUSH, VAL_MOST_NEG, PICK_P5);
    send_item(ACT_PUSH, VAL_MOST_POS, PICK_P5);
    send_item(ACT_PUSH, -1, PICK_P5);
    send_item(ACT_PUSH, 1, PICK_P5);
    send_item(ACT_PUSH, 1, PICK_P5);
    send_item(ACT_MIN, 0, PICK_P5);
    send_item(ACT_MAX, 0, PICK_P5);
    send_item(ACT_QUANT, 0, PICK_P5);
    send_item(ACT_QUANT, 0, PICK_P25);
    send_item(ACT_QUANT, 0, PICK_P50);
    send_item(ACT_QUANT, 0, PICK_P75);
    send_item(ACT_QUANT, VAL_MOST_NEG, PICK_P95);
    send_item(ACT_QUANT, VAL_MOST_POS, PICK_UNUSED_LO);
    // zero total: the first entry answers every valid pick
    write_total(24'd0);
    send_item(ACT_QUANT, 0, PICK_P95);
    write_total(24'hFF_FFFF);
    send_item(ACT_QUANT, 0, PICK_P5);
  endtask

  task automatic test_output_stall();
    write_total(TOTAL_RESET);
    rx_hold_req = 1'b1;
    repeat (12) send_random_item(1'b0);
    wait_drained();
  endtask

  task automatic test_random_mix();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_total(24'($urandom_range(50, 600)));
        1:       write_total(24'd1);
        2:       write_total(24'hFF_FFFF);
        default: write_total(24'($urandom_range(100, 800)));
      endcase
      repeat (200) send_random_item(1'b0);
    end
  endtask

  task automatic test_table_full();
    while (hist_used < TABLE_DEPTH) send_item(ACT_PUSH, $urandom, 3'($urandom_range(0, 7)));
    // fresh values now get dropped, stored ones still count
    repeat (4) send_item(ACT_PUSH, $urandom, 3'($urandom_range(0, 7)));
    send_item(ACT_PUSH, hist_value[TABLE_DEPTH/2], PICK_P5);
    send_item(ACT_PUSH, VAL_MOST_POS, PICK_P5);
    send_item(ACT_MIN, 0, PICK_P5);
    send_item(ACT_MAX, 0, PICK_P5);
    send_item(ACT_QUANT, 0, PICK_P50);
    send_item(ACT_QUANT, 0, PICK_P95);
  endtask

  task automatic test_full_table_traffic();
    write_total(24'($urandom_range(200, 2000)));
    repeat (500) send_random_item(1'b1);
    // long stretch with no random idle cycles on either stream
    idle_on = 1'b0;
    write_total(24'($urandom_range(1, 3000)));
    repeat (500) send_random_item(1'b1);
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = ACT_PUSH;
    in_tvalid   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      hist_value[k] = '0;
      hist_count[k] = '0;
    end
    hist_used = 1;
    total_cfg = TOTAL_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_edge_values();
    test_output_stall();
    test_random_mix();
    test_table_full();
    test_full_table_traffic();

    wait_drained();
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("PASS sorted_histogram_quantile_core");
    end else begin
      $display("FAIL sorted_histogram_quantile_core");
    end
    $finish;
  end

endmodule

// ----- sorted_histogram_quantile_core.f -----
design/shq_pkg.sv
design/shq_ram.sv
design/shq_alu.sv
design/sorted_histogram_quantile_core.sv
sim/sorted_histogram_quantile_core_test.sv
